// ===== rtl/core/bste_pkg.sv =====
package bste_pkg;

   // Fixed-point reciprocal of 100: floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT
   // for x below 2**23.
   localparam int unsigned RECIP_SHIFT = 30;
   localparam logic [23:0] RECIP_100 = 24'd10737419;

   localparam logic [6:0] PCT_FULL = 7'd100;
   localparam logic [7:0] PCT_MAX = 8'd100;
   localparam logic [5:0] MIN_PER_HOUR = 6'd60;
   localparam logic [16:0] MIN_CURRENT = 17'd5;
   localparam logic [2:0] CHG_DONE = 3'd4;

   // Divider geometry: 20 quotient bits, 4 per stage.
   localparam int unsigned DIV_STEPS = 4;
   localparam int unsigned DIV_STAGES = 5;

   typedef struct packed {
      logic [7:0] soc_percent;
      logic [7:0] soh_percent;
      logic signed [15:0] battery_current;
      logic pack_detected;
      logic vbus_good;
      logic [2:0] charger_state;
   } req_type;

   typedef struct packed {
      logic reading_valid;
      logic capacity_known;
      logic is_charging;
      logic is_full;
      logic is_empty;
      logic [6:0] effective_health;
      logic [15:0] full_capacity;
      logic [15:0] remaining_capacity;
      logic [19:0] minutes_to_full;
      logic [19:0] minutes_to_empty;
   } rsp_type;

   // Derated capacity stage output
   typedef struct packed {
      req_type req;
      logic [15:0] cap;
      logic cap_known;
      logic [6:0] eff_health;
   } capo_type;

   // Sideband carried through the divider
   typedef struct packed {
      rsp_type rsp;
      logic to_full;
      logic min_on;
   } side_type;

   typedef struct packed {
      logic [21:0] rem;
      logic [19:0] low;
      logic [19:0] quo;
      logic [21:0] dvs;
      side_type side;
   } dstage_type;

   // Four restoring division steps
   function automatic dstage_type div_step(input dstage_type s);
      dstage_type o;
      logic [22:0] r;
      o = s;
      for (int i = 0; i < DIV_STEPS; i++) begin
         r = {o.rem, o.low[19]};
         o.low = {o.low[18:0], 1'b0};
         if (r >= {1'b0, o.dvs}) begin
            r = r - {1'b0, o.dvs};
            o.quo = {o.quo[18:0], 1'b1};
         end else begin
            o.quo = {o.quo[18:0], 1'b0};
         end
         o.rem = r[21:0];
      end
      return o;
   endfunction

endpackage

// ===== rtl/core/bste_cap.sv =====
module bste_cap (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  bste_pkg::req_type in_req,
   input  logic [15:0] rated,
   output logic out_valid,
   output bste_pkg::capo_type out_cap
);

   logic v1_ff, v2_ff, v3_ff;
   bste_pkg::req_type req1_ff, req2_ff, req3_ff;
   logic [15:0] rated1_ff, rated2_ff, rated3_ff;
   logic hok2_ff, hok3_ff;
   logic [6:0] eh2_ff, eh3_ff;
   logic [22:0] prod2_ff;
   logic [46:0] recip3_ff;
   logic hok1;
   logic [6:0] eh1;
   logic [15:0] quot3;

   // stage 1 health check
   assign hok1 = (req1_ff.soh_percent != 8'd0) &&
                 (req1_ff.soh_percent <= bste_pkg::PCT_MAX);
   assign eh1 = hok1 ? req1_ff.soh_percent[6:0] : bste_pkg::PCT_FULL;

   // valid pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // payload: capture, rated*health, then reciprocal multiply
   always_ff @(posedge clock) begin
      req1_ff <= in_req;
      rated1_ff <= rated;
      req2_ff <= req1_ff;
      rated2_ff <= rated1_ff;
      hok2_ff <= hok1;
      eh2_ff <= eh1;
      prod2_ff <= 23'(rated1_ff * eh1);
      req3_ff <= req2_ff;
      rated3_ff <= rated2_ff;
      hok3_ff <= hok2_ff;
      eh3_ff <= eh2_ff;
      recip3_ff <= 47'(prod2_ff * bste_pkg::RECIP_100);
   end

   assign quot3 = recip3_ff[45:30];

   // usable capacity select
   always_comb begin
      out_cap.req = req3_ff;
      out_cap.eff_health = eh3_ff;
      out_cap.cap_known = (rated3_ff != 16'd0);
      if (rated3_ff == 16'd0) begin
         out_cap.cap = 16'd0;
      end else if (!hok3_ff) begin
         out_cap.cap = rated3_ff;
      end else if (quot3 == 16'd0) begin
         out_cap.cap = 16'd1;
      end else begin
         out_cap.cap = quot3;
      end
   end
   assign out_valid = v3_ff;

endmodule

// ===== rtl/core/bste_div.sv =====
module bste_div (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic [28:0] num,
   input  logic [21:0] dvs,
   input  bste_pkg::side_type in_side,
   output logic out_valid,
   output logic [19:0] quo,
   output bste_pkg::side_type out_side
);

   bste_pkg::dstage_type stg_ff [bste_pkg::DIV_STAGES];
   logic v_ff [bste_pkg::DIV_STAGES];
   bste_pkg::dstage_type first;

   // high numerator bits preload the remainder
   always_comb begin
      first.rem = {13'd0, num[28:20]};
      first.low = num[19:0];
      first.quo = 20'd0;
      first.dvs = dvs;
      first.side = in_side;
   end

   for (genvar k = 0; k < bste_pkg::DIV_STAGES; k++) begin : g_stage
      if (k == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else begin
               v_ff[k] <= in_valid;
            end
         end
         always_ff @(posedge clock) begin
            stg_ff[k] <= bste_pkg::div_step(first);
         end
      end else begin : g_rest
         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else begin
               v_ff[k] <= v_ff[k-1];
            end
         end
         always_ff @(posedge clock) begin
            stg_ff[k] <= bste_pkg::div_step(stg_ff[k-1]);
         end
      end
   end

   assign out_valid = v_ff[bste_pkg::DIV_STAGES-1];
   assign quo = stg_ff[bste_pkg::DIV_STAGES-1].quo;
   assign out_side = stg_ff[bste_pkg::DIV_STAGES-1].side;

endmodule

// ===== rtl/core/battery_status_time_estimator.sv =====
// Battery status and time estimator.
// Request channel: drive req_data and pulse start; a transaction is taken on
// any edge with start high and busy low. busy is always low, so one reading
// can enter every cycle.
// Config channel: csr_data is the rated capacity in mAh, written when
// csr_valid and csr_ready are high; csr_ready is always high. Write it only
// while no readings are in flight.
// Response channel: rsp_valid strobes for one cycle with rsp_data; the
// receiver must take it then, as it cannot stall the pipeline.
// From accept to strobe, registered stages first derive the usable
// capacity (health multiply, reciprocal divide by 100), then form the
// remaining capacity and the minute-estimate operands, and last run the
// restoring divider at four quotient bits per stage.
// Throughput is one reading per cycle.
// Synchronous reset clears all valid bits and sets rated capacity to 0;
// readings in flight at reset are dropped.
module battery_status_time_estimator (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  bste_pkg::req_type req_data,
   output logic rsp_valid,
   output bste_pkg::rsp_type rsp_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [15:0] csr_data
);

   logic [15:0] rated_ff;
   logic cv;
   bste_pkg::capo_type co;

   logic v4_ff, v5_ff;
   bste_pkg::capo_type c4_ff, c5_ff;
   logic chg4_ff, chg5_ff, mlow4_ff, mlow5_ff;
   logic [22:0] mp4_ff;
   logic [28:0] num4_ff, num5_ff;
   logic [21:0] d4_ff, d5_ff;
   logic [46:0] rc5_ff;

   logic [16:0] mag;
   logic chg;
   logic [6:0] remp;
   logic [12:0] rem60;
   bste_pkg::side_type side5;
   logic dv;
   logic [19:0] dq;
   bste_pkg::side_type dside;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   // rated capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         rated_ff <= 16'd0;
      end else if (csr_valid && csr_ready) begin
         rated_ff <= csr_data;
      end
   end

   bste_cap u_cap (
      .clock(clock),
      .reset(reset),
      .in_valid(start && !busy),
      .in_req(req_data),
      .rated(rated_ff),
      .out_valid(cv),
      .out_cap(co)
   );

   // stage 4 operands
   assign mag = co.req.battery_current[15] ?
                17'(17'h10000 - {1'b0, co.req.battery_current}) :
                {1'b0, co.req.battery_current};
   assign chg = co.req.pack_detected && co.req.vbus_good &&
                (co.req.charger_state <= bste_pkg::CHG_DONE);
   assign remp = chg ? 7'(bste_pkg::PCT_FULL - co.req.soc_percent[6:0]) :
                 co.req.soc_percent[6:0];
   assign rem60 = 13'(remp * bste_pkg::MIN_PER_HOUR);

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v4_ff <= cv;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      c4_ff <= co;
      chg4_ff <= chg;
      mlow4_ff <= (mag < bste_pkg::MIN_CURRENT);
      mp4_ff <= 23'(co.cap * co.req.soc_percent[6:0]);
      num4_ff <= 29'(co.cap * rem60);
      d4_ff <= 22'(mag * bste_pkg::PCT_FULL);
      c5_ff <= c4_ff;
      chg5_ff <= chg4_ff;
      mlow5_ff <= mlow4_ff;
      num5_ff <= num4_ff;
      d5_ff <= d4_ff;
      rc5_ff <= 47'(mp4_ff * bste_pkg::RECIP_100);
   end

   // response fields, invalid readings forced to zero
   always_comb begin
      side5 = '0;
      if (c5_ff.req.soc_percent <= bste_pkg::PCT_MAX) begin
         side5.rsp.reading_valid = 1'b1;
         side5.rsp.capacity_known = c5_ff.cap_known;
         side5.rsp.is_charging = chg5_ff;
         side5.rsp.is_full = (c5_ff.req.charger_state == bste_pkg::CHG_DONE) ||
                             (c5_ff.req.soc_percent == bste_pkg::PCT_MAX);
         side5.rsp.is_empty = c5_ff.req.pack_detected &&
                              (c5_ff.req.soc_percent == 8'd0);
         side5.rsp.effective_health = c5_ff.eff_health;
         side5.rsp.full_capacity = c5_ff.cap;
         side5.rsp.remaining_capacity = rc5_ff[45:30];
         side5.to_full = chg5_ff;
         side5.min_on = c5_ff.cap_known && !mlow5_ff;
      end
   end

   bste_div u_div (
      .clock(clock),
      .reset(reset),
      .in_valid(v5_ff),
      .num(num5_ff),
      .dvs(d5_ff),
      .in_side(side5),
      .out_valid(dv),
      .quo(dq),
      .out_side(dside)
   );

   // route the estimate to the proper minute field
   always_comb begin
      rsp_data = dside.rsp;
      rsp_data.minutes_to_full = (dside.min_on && dside.to_full) ? dq : 20'd0;
      rsp_data.minutes_to_empty = (dside.min_on && !dside.to_full) ? dq : 20'd0;
   end
   assign rsp_valid = dv;

endmodule

// ===== dv/tb_battery_status_time_estimator.sv =====
module tb_battery_status_time_estimator;

   localparam int LATENCY = 10;
   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_READINGS = 850;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   bste_pkg::req_type req_data;
   logic rsp_valid;
   bste_pkg::rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [15:0] csr_data;

   battery_status_time_estimator i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // Directed stimulus row: typed-in expectation only where has_rsp is set
   typedef struct {
      logic [7:0] pct;
      logic [7:0] health;
      logic [15:0] current;
      logic pack;
      logic vbus;
      logic [2:0] cstate;
      logic has_rsp;
      bste_pkg::rsp_type rsp;
   } row_type;

   logic [15:0] rated_cap;
   bste_pkg::rsp_type estimate_queue[$];
   int mismatch_count;
   int idle_cycles;
   int readings_sent;
   int estimates_seen;
   int send_idle_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bste_pkg::rsp_type predict_status(bste_pkg::req_type r,
                                                        logic [15:0] rated);
      bste_pkg::rsp_type o;
      logic [31:0] cap;
      logic [16:0] mag;
      logic charging;
      logic [63:0] num;
      logic [31:0] mins;
      o = '0;
      if (r.soc_percent > 8'd100) return o;
      mag = r.battery_current[15] ? 17'h10000 - {1'b0, r.battery_current} :
            {1'b0, r.battery_current};
      if (rated == 0) cap = 0;
      else if (r.soh_percent == 0 || r.soh_percent > 100) cap = 32'(rated);
      else begin
         cap = rated * r.soh_percent / 100;
         if (cap < 1) cap = 1;
      end
      charging = r.pack_detected && r.vbus_good && r.charger_state <= bste_pkg::CHG_DONE;
      o.reading_valid = 1'b1;
      o.capacity_known = rated != 0;
      o.is_charging = charging;
      o.is_full = r.charger_state == bste_pkg::CHG_DONE || r.soc_percent == 8'd100;
      o.is_empty = r.pack_detected && r.soc_percent == 0;
      o.effective_health = (r.soh_percent >= 1 && r.soh_percent <= 100) ?
                           r.soh_percent[6:0] : 7'd100;
      o.full_capacity = cap[15:0];
      o.remaining_capacity = 16'(cap * r.soc_percent / 100);
      mins = 0;
      if (cap != 0 && mag >= 5) begin
         num = 64'(cap) * (charging ? 64'(100 - r.soc_percent) : 64'(r.soc_percent)) * 60;
         mins = 32'(num / (64'd100 * mag));
      end
      if (charging) o.minutes_to_full = mins[19:0];
      else o.minutes_to_empty = mins[19:0];
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   // Result checker, sampled at the rising edge
   always @(posedge clock) begin
      bste_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         estimates_seen++;
         if (estimate_queue.size() == 0) begin
            report_mismatch("unexpected transaction", 1, 0);
         end else begin
            want = estimate_queue.pop_front();
            if (rsp_data.reading_valid != want.reading_valid)
               report_mismatch("reading_valid", 32'(rsp_data.reading_valid),
                               32'(want.reading_valid));
            if (rsp_data.capacity_known != want.capacity_known)
               report_mismatch("capacity_known", 32'(rsp_data.capacity_known),
                               32'(want.capacity_known));
            if (rsp_data.is_charging != want.is_charging)
               report_mismatch("is_charging", 32'(rsp_data.is_charging),
                               32'(want.is_charging));
            if (rsp_data.is_full != want.is_full)
               report_mismatch("is_full", 32'(rsp_data.is_full), 32'(want.is_full));
            if (rsp_data.is_empty != want.is_empty)
               report_mismatch("is_empty", 32'(rsp_data.is_empty), 32'(want.is_empty));
            if (rsp_data.effective_health != want.effective_health)
               report_mismatch("effective_health", 32'(rsp_data.effective_health),
                               32'(want.effective_health));
            if (rsp_data.full_capacity != want.full_capacity)
               report_mismatch("full_capacity", 32'(rsp_data.full_capacity),
                               32'(want.full_capacity));
            if (rsp_data.remaining_capacity != want.remaining_capacity)
               report_mismatch("remaining_capacity", 32'(rsp_data.remaining_capacity),
                               32'(want.remaining_capacity));
            if (rsp_data.minutes_to_full != want.minutes_to_full)
               report_mismatch("minutes_to_full", 32'(rsp_data.minutes_to_full),
                               32'(want.minutes_to_full));
            if (rsp_data.minutes_to_empty != want.minutes_to_empty)
               report_mismatch("minutes_to_empty", 32'(rsp_data.minutes_to_empty),
                               32'(want.minutes_to_empty));
         end
      end
   end

   // Watchdog on cycles with no transaction
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || (csr_valid && csr_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog expired");
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Send one reading; start stays high across back-to-back transactions
   task automatic send_reading(bste_pkg::req_type r, logic has_rsp, bste_pkg::rsp_type typed);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      if (has_rsp) estimate_queue.push_back(typed);
      else estimate_queue.push_back(predict_status(r, rated_cap));
      readings_sent++;
      @(negedge clock);
   endtask

   task automatic drain_pipeline();
      start <= 1'b0;
      while (estimate_queue.size() != 0) @(negedge clock);
      repeat (LATENCY + 2) @(negedge clock);
   endtask

   task automatic write_capacity(logic [15:0] value);
      drain_pipeline();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      rated_cap = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic bste_pkg::req_type random_reading();
      bste_pkg::req_type r;
      logic [63:0] rnd;
      rnd = {$urandom, $urandom};
      r = rnd[$bits(bste_pkg::req_type)-1:0];
      case ($urandom_range(9))
         0: r.soc_percent = 8'($urandom_range(101, 255));
         1: r.soc_percent = ($urandom_range(1)) ? 8'd0 : 8'd100;
         default: r.soc_percent = 8'($urandom_range(100));
      endcase
      case ($urandom_range(7))
         0: r.soh_percent = 8'($urandom_range(101, 255));
         1: r.soh_percent = 8'd0;
         default: r.soh_percent = 8'($urandom_range(1, 100));
      endcase
      if ($urandom_range(5) == 0) r.battery_current = 16'($urandom_range(0, 6)) -
                                                      16'($urandom_range(0, 6));
      return r;
   endfunction

   row_type rows[$];

   function automatic row_type mk(logic [7:0] p, logic [7:0] h, logic [15:0] c,
                                  logic pk, logic vb, logic [2:0] cs);
      row_type r;
      r.pct = p; r.health = h; r.current = c; r.pack = pk; r.vbus = vb; r.cstate = cs;
      r.has_rsp = 1'b0; r.rsp = '0;
      return r;
   endfunction

   initial begin
      bste_pkg::req_type r;
      row_type row;
      logic [15:0] caps[6];
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      rated_cap = '0;
      mismatch_count = 0;
      readings_sent = 0;
      estimates_seen = 0;
      send_idle_pct = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table: after reset capacity is unset, invalid reading is all zero
      row = mk(8'd255, 8'd50, 16'd100, 1'b1, 1'b1, 3'd2);
      row.has_rsp = 1'b1;
      rows.push_back(row);
      row = mk(8'd101, 8'd0, 16'h8000, 1'b1, 1'b1, 3'd4);
      row.has_rsp = 1'b1;
      rows.push_back(row);
      row = mk(8'd0, 8'd0, 16'd0, 1'b1, 1'b0, 3'd7);
      row.has_rsp = 1'b1;
      row.rsp = '0;
      row.rsp.reading_valid = 1'b1; row.rsp.is_empty = 1'b1;
      row.rsp.effective_health = 7'd100;
      rows.push_back(row);
      foreach (rows[i]) begin
         r = '{rows[i].pct, rows[i].health, rows[i].current, rows[i].pack,
               rows[i].vbus, rows[i].cstate};
         send_reading(r, rows[i].has_rsp, rows[i].rsp);
      end
      rows.delete();

      // Directed rows with capacity set, checked against the predictor
      write_capacity(16'hFFFF);
      rows.push_back(mk(8'd100, 8'd100, 16'd5, 1'b1, 1'b1, 3'd0));
      rows.push_back(mk(8'd0, 8'd100, 16'd5, 1'b1, 1'b1, 3'd1));
      rows.push_back(mk(8'd100, 8'd1, 16'h8000, 1'b1, 1'b0, 3'd5));
      rows.push_back(mk(8'd50, 8'd255, 16'd4, 1'b0, 1'b1, 3'd6));
      rows.push_back(mk(8'd50, 8'd101, 16'hFFFC, 1'b1, 1'b1, 3'd3));
      rows.push_back(mk(8'd1, 8'd99, 16'h7FFF, 1'b1, 1'b1, 3'd4));
      rows.push_back(mk(8'd99, 8'd0, 16'hFFFB, 1'b0, 1'b0, 3'd2));
      rows.push_back(mk(8'd100, 8'd100, 16'h8000, 1'b0, 1'b0, 3'd7));
      foreach (rows[i]) begin
         r = '{rows[i].pct, rows[i].health, rows[i].current, rows[i].pack,
               rows[i].vbus, rows[i].cstate};
         send_reading(r, 1'b0, '0);
      end
      write_capacity(16'd1);
      foreach (rows[i]) begin
         r = '{rows[i].pct, rows[i].health, rows[i].current, rows[i].pack,
               rows[i].vbus, rows[i].cstate};
         send_reading(r, 1'b0, '0);
      end

      // Random phases across capacity settings and idling patterns
      caps = '{16'd0, 16'd1, 16'hFFFF, 16'd3000, 16'($urandom), 16'($urandom_range(1, 200))};
      for (int ph = 0; ph < 6; ph++) begin
         write_capacity(caps[ph]);
         send_idle_pct = (ph < 2) ? 32 : (ph < 4) ? 80 : 0;
         for (int n = 0; n < RANDOM_READINGS / 6; n++) begin
            send_reading(random_reading(), 1'b0, '0);
            // Hold-off until the pipeline has emptied
            if (n == 40) drain_pipeline();
         end
      end

      drain_pipeline();
      $display("covered %0d readings, %0d results, capacity from 0 to 65535", readings_sent,
               estimates_seen);
      $display("idle patterns, invalid readings, small and most negative currents exercised");
      if (mismatch_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule
